// ----- rtl/core/tal_pkg.sv -----
// ----------------------------------------------------------------------------
// tal_pkg
// Shared constants and helpers for the kerned text advance layout unit.
// ----------------------------------------------------------------------------
package tal_pkg;

  localparam int GLYPH_W = 7;
  localparam int POS_W   = 16;
  localparam int CODE_W  = 8;
  localparam int SPACE_W = 8;

  localparam logic MODE_WRITE  = 1'b0;
  localparam logic MODE_LAYOUT = 1'b1;

  localparam logic [CODE_W-1:0] CODE_SQUOTE     = 8'd39;
  localparam logic [CODE_W-1:0] CODE_DQUOTE     = 8'd34;
  localparam logic [CODE_W-1:0] FIRST_PRINTABLE = 8'd32;
  localparam logic [CODE_W-1:0] CODE_LIMIT      = 8'd128;
  localparam int                RESERVED_GLYPHS = 3;

  localparam logic [GLYPH_W-1:0] GLYPH_SPACE = 7'd0;
  localparam logic [GLYPH_W-1:0] OPEN_SINGLE = 7'd96;
  localparam logic [GLYPH_W-1:0] OPEN_DOUBLE = 7'd97;

  localparam logic [SPACE_W-1:0] SPACE_RESET = 8'd4;

  // byte to glyph; quotes after a space open, unprintable is space, else clamp
  function automatic logic [GLYPH_W-1:0] map_glyph(input logic [CODE_W-1:0] code,
                                                   input logic              after,
                                                   input logic [CODE_W-1:0] clamp);
    logic [CODE_W-1:0] g;
    g = code - FIRST_PRINTABLE;
    if (after && code == CODE_SQUOTE) return OPEN_SINGLE;
    if (after && code == CODE_DQUOTE) return OPEN_DOUBLE;
    if (code < FIRST_PRINTABLE || code >= CODE_LIMIT) return GLYPH_SPACE;
    if (g > clamp) g = clamp;
    return g[GLYPH_W-1:0];
  endfunction

  function automatic logic [POS_W-1:0] sat_add(input logic [POS_W-1:0] a,
                                               input logic [POS_W-1:0] b);
    logic [POS_W:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[POS_W] ? {POS_W{1'b1}} : s[POS_W-1:0];
  endfunction

endpackage

// ----- rtl/core/text_advance_layout_unit.sv -----
// ----------------------------------------------------------------------------
// text_advance_layout_unit
// Pairwise kerned pen advance for a byte string, with a loadable pair table.
// ----------------------------------------------------------------------------
// Takes one word per clock while s_tready is high, table writes and characters
// alike, and passes each character's result through the stage 1, stage 2 and
// output registers. The pair table is a single memory, read once per
// character on two ports at once (the pair advance and the end-of-line
// advance); the glyph map and the previous glyph are resolved in the
// cycle the word is taken. The table is not cleared at reset: every pair a
// string uses must be loaded first.
module text_advance_layout_unit #(
  parameter int GLYPH_COUNT  = 98,
  parameter int ADVANCE_BITS = 8
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [7:0]  cfg_data,      // space_width
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [31:0] s_tdata,       // pair_first, pair_second, pair_advance, char_code
  input  logic        s_tuser,       // mode
  input  logic        s_tlast,       // last_char
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [39:0] m_tdata,       // glyph_index, pen_x, total_width
  output logic        m_tuser,       // is_space
  output logic        m_tlast        // string_done
);

  localparam int DEPTH = GLYPH_COUNT * GLYPH_COUNT;
  localparam int AW    = $clog2(DEPTH);
  localparam logic [tal_pkg::CODE_W-1:0] CLAMP =
    tal_pkg::CODE_W'(GLYPH_COUNT - tal_pkg::RESERVED_GLYPHS);

  localparam int GW = tal_pkg::GLYPH_W;
  localparam int PW = tal_pkg::POS_W;

  function automatic logic [AW-1:0] pair_addr(input logic [GW-1:0] first,
                                              input logic [GW-1:0] second);
    return AW'(first) * AW'(GLYPH_COUNT) + AW'(second);
  endfunction

  function automatic logic in_range(input logic [GW-1:0] g);
    return 32'(g) < 32'(GLYPH_COUNT);
  endfunction

  // input word
  logic [GW-1:0] pair_first, pair_second;
  logic [7:0]    pair_advance;
  logic [7:0]    char_code;

  assign pair_first   = s_tdata[6:0];
  assign pair_second  = s_tdata[13:7];
  assign pair_advance = s_tdata[21:14];
  assign char_code    = s_tdata[29:22];

  logic [7:0]    space_width;
  logic [GW-1:0] prev_glyph;
  logic          after_space;
  logic [PW-1:0] running_width;

  logic v1, v2;
  logic p2, p3;
  logic in_fire, lay_fire, wr_fire;

  assign cfg_ready = 1'b1;
  assign p3        = !m_tvalid || m_tready;
  assign p2        = !v2 || p3;
  assign s_tready  = !v1 || p2;
  assign in_fire   = s_tvalid && s_tready;
  assign lay_fire  = in_fire && s_tuser == tal_pkg::MODE_LAYOUT;
  assign wr_fire   = in_fire && s_tuser == tal_pkg::MODE_WRITE;

  // glyph resolution in the accept cycle
  logic [GW-1:0] glyph, prev_after;
  logic          is_sp, is_quote, ok_a, ok_b, ok_w;
  logic [AW-1:0] addr_a, addr_b, addr_w;

  always_comb begin
    glyph      = tal_pkg::map_glyph(char_code, after_space, CLAMP);
    is_sp      = glyph == tal_pkg::GLYPH_SPACE;
    is_quote   = char_code == tal_pkg::CODE_SQUOTE || char_code == tal_pkg::CODE_DQUOTE;
    prev_after = is_sp ? prev_glyph : glyph;
    ok_a       = prev_glyph != tal_pkg::GLYPH_SPACE && in_range(prev_glyph) && in_range(glyph);
    ok_b       = prev_after != tal_pkg::GLYPH_SPACE && in_range(prev_after);
    ok_w       = pair_first != tal_pkg::GLYPH_SPACE && in_range(pair_first)
                 && in_range(pair_second);
    addr_a     = ok_a ? pair_addr(prev_glyph, glyph) : '0;
    addr_b     = ok_b ? pair_addr(prev_after, tal_pkg::GLYPH_SPACE) : '0;
    addr_w     = pair_addr(pair_first, pair_second);
  end

  logic [ADVANCE_BITS-1:0] rd_a, rd_b;

  tal_adv_mem #(
    .DEPTH  (DEPTH),
    .DATA_W (ADVANCE_BITS)
  ) u_mem (
    .clk     (clk),
    .we      (wr_fire && ok_w),
    .waddr   (addr_w),
    .wdata   (ADVANCE_BITS'(pair_advance)),
    .re      (lay_fire),
    .raddr_a (addr_a),
    .raddr_b (addr_b),
    .rdata_a (rd_a),
    .rdata_b (rd_b)
  );

  // stage 1 payload
  logic [GW-1:0] g1;
  logic          sp1, last1, oka1, okb1;

  // stage 2 payload
  logic [GW-1:0]           g2;
  logic [PW-1:0]           pen2;
  logic                    sp2, last2;
  logic [ADVANCE_BITS-1:0] end2;

  logic [PW-1:0] step_adv, running_width_next;

  always_comb begin
    step_adv = '0;
    if (sp1) begin
      step_adv = PW'(space_width);
    end else if (oka1) begin
      step_adv = PW'(rd_a);
    end
    running_width_next = tal_pkg::sat_add(running_width, step_adv);
  end

  // control
  always_ff @(posedge clk) begin
    if (rst) begin
      space_width   <= tal_pkg::SPACE_RESET;
      prev_glyph    <= tal_pkg::GLYPH_SPACE;
      after_space   <= 1'b1;
      running_width <= '0;
      v1            <= 1'b0;
      v2            <= 1'b0;
      m_tvalid      <= 1'b0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        space_width <= cfg_data;
      end
      if (lay_fire) begin
        if (s_tlast) begin
          prev_glyph  <= tal_pkg::GLYPH_SPACE;
          after_space <= 1'b1;
        end else begin
          if (!is_sp) prev_glyph <= glyph;
          if (!is_quote) after_space <= is_sp;
        end
      end
      if (v1 && p2) begin
        running_width <= last1 ? '0 : running_width_next;
      end
      if (s_tready) v1 <= lay_fire;
      if (p2) v2 <= v1;
      if (p3) m_tvalid <= v2;
    end
  end

  // payload
  always_ff @(posedge clk) begin
    if (lay_fire) begin
      g1    <= glyph;
      sp1   <= is_sp;
      last1 <= s_tlast;
      oka1  <= ok_a;
      okb1  <= ok_b;
    end
    if (v1 && p2) begin
      g2    <= g1;
      pen2  <= running_width_next;
      sp2   <= sp1;
      last2 <= last1;
      end2  <= (last1 && okb1) ? rd_b : '0;
    end
    if (v2 && p3) begin
      m_tdata[6:0]   <= g2;
      m_tdata[22:7]  <= pen2;
      m_tdata[38:23] <= last2 ? tal_pkg::sat_add(pen2, PW'(end2)) : '0;
      m_tdata[39]    <= 1'b0;
      m_tuser        <= sp2;
      m_tlast        <= last2;
    end
  end

endmodule

// ----- rtl/core/tal_adv_mem.sv -----
// ----------------------------------------------------------------------------
// tal_adv_mem
// Pair advance table: one write port, two registered read ports.
// ----------------------------------------------------------------------------
module tal_adv_mem #(
  parameter int  DEPTH  = 9604,
  parameter int  DATA_W = 8,
  localparam int AW     = $clog2(DEPTH)
) (
  input  logic              clk,
  input  logic              we,
  input  logic [AW-1:0]     waddr,
  input  logic [DATA_W-1:0] wdata,
  input  logic              re,
  input  logic [AW-1:0]     raddr_a,
  input  logic [AW-1:0]     raddr_b,
  output logic [DATA_W-1:0] rdata_a,
  output logic [DATA_W-1:0] rdata_b
);

  logic [DATA_W-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_a <= mem[raddr_a];
      rdata_b <= mem[raddr_b];
    end
  end

endmodule

// ----- rtl/core/tal_checker.sv -----
// ----------------------------------------------------------------------------
// tal_checker
// Port-level checks on the result stream of the text advance layout unit.
// ----------------------------------------------------------------------------
module tal_checker (
  input logic        clk,
  input logic        rst,
  input logic        m_tvalid,
  input logic        m_tready,
  input logic [39:0] m_tdata,
  input logic        m_tuser,
  input logic        m_tlast
);

  // a stalled word holds
  a_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser)
      && $stable(m_tlast))
    else $error("result word changed while stalled");

  a_total_zero: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tlast |-> m_tdata[38:23] == 16'd0)
    else $error("total width set before end of string");

  a_space_glyph: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> m_tuser == (m_tdata[6:0] == 7'd0))
    else $error("space flag disagrees with glyph");

  a_total_ge_pen: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tlast |-> m_tdata[38:23] >= m_tdata[22:7])
    else $error("total width below final pen position");

endmodule

bind text_advance_layout_unit tal_checker u_tal_checker (
  .clk      (clk),
  .rst      (rst),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata),
  .m_tuser  (m_tuser),
  .m_tlast  (m_tlast)
);

// ----- verif/text_advance_layout_unit_test.sv -----
// ----------------------------------------------------------------------------
// text_advance_layout_unit_test
// Self-checking bench for the kerned text advance layout unit.
// ----------------------------------------------------------------------------
// Lays out space-only strings, loads the pair table for a small glyph alphabet,
// then lays out directed and random strings over that alphabet under several
// idling mixes and space widths. Every character word is predicted in the bench
// and each result word is compared field by field in order.
// ----------------------------------------------------------------------------
module text_advance_layout_unit_test;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int GW           = tal_pkg::GLYPH_W;
  localparam int PW           = tal_pkg::POS_W;
  localparam int SW           = tal_pkg::SPACE_W;
  localparam int NGLYPH       = 98;
  localparam int LAST_GLYPH   = NGLYPH - tal_pkg::RESERVED_GLYPHS;
  localparam int WIDTH_MAX    = 65535;
  localparam int SETTLE_TICKS = 8;
  localparam int PHASE_WORDS  = 25;
  localparam int N_ALPHA      = 8;

  typedef struct packed {
    logic [GW-1:0] glyph;
    logic [PW-1:0] pen;
    logic          space;
    logic          done;
    logic [PW-1:0] total;
  } layout_res_t;

  logic        clk;
  logic        rst;
  logic        cfg_valid;
  logic        cfg_ready;
  logic [7:0]  cfg_data;
  logic        s_tvalid;
  logic        s_tready;
  logic [31:0] s_tdata;
  logic        s_tuser;
  logic        s_tlast;
  logic        m_tvalid;
  logic        m_tready;
  logic [39:0] m_tdata;
  logic        m_tuser;
  logic        m_tlast;

  text_advance_layout_unit uut (
    .clk      (clk),
    .rst      (rst),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_data (cfg_data),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .s_tlast  (s_tlast),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .m_tlast  (m_tlast)
  );

  // shadow layout state
  logic [7:0]    adv_tbl [NGLYPH][NGLYPH];
  logic [PW-1:0] pen_acc;
  logic [GW-1:0] prev_glyph;
  logic          after_sp;
  logic [SW-1:0] space_px;

  layout_res_t pending_layout[$];

  int gap_pct;
  int stall_pct;
  int hold_req;
  int hold_left;
  int mism;
  int n_checked;
  int n_chars;
  int n_writes;
  int n_strings;
  int n_cfg;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #3000000;
    $display("Verification failed");
    $finish;
  end

  // drawn glyphs the strings can reach: plain and opening quotes, A, a, tilde, delete
  function automatic int alpha_glyph(input int k);
    case (k)
      0:       return 2;
      1:       return 7;
      2:       return 33;
      3:       return 65;
      4:       return 94;
      5:       return 95;
      6:       return int'(tal_pkg::OPEN_SINGLE);
      default: return int'(tal_pkg::OPEN_DOUBLE);
    endcase
  endfunction

  function automatic int pair_adv(input int first, input int second);
    if (first == 0 || first >= NGLYPH || second >= NGLYPH) return 0;
    return int'(adv_tbl[first][second]);
  endfunction

  function automatic logic [PW-1:0] clip_add(input int a, input int b);
    int s;
    s = a + b;
    return (s > WIDTH_MAX) ? PW'(WIDTH_MAX) : PW'(s);
  endfunction

  function automatic void store_pair(input int first, input int second, input int adv);
    if (first != 0 && first < NGLYPH && second < NGLYPH) adv_tbl[first][second] = 8'(adv);
  endfunction

  function automatic void place_char(input logic [7:0] code, input logic last);
    int          idx;
    layout_res_t r;
    idx = int'(code) - int'(tal_pkg::FIRST_PRINTABLE);
    if (after_sp && code == tal_pkg::CODE_SQUOTE) r.glyph = tal_pkg::OPEN_SINGLE;
    else if (after_sp && code == tal_pkg::CODE_DQUOTE) r.glyph = tal_pkg::OPEN_DOUBLE;
    else if (code < tal_pkg::FIRST_PRINTABLE || code >= tal_pkg::CODE_LIMIT)
      r.glyph = tal_pkg::GLYPH_SPACE;
    else if (idx > LAST_GLYPH) r.glyph = GW'(LAST_GLYPH);
    else r.glyph = GW'(idx);
    r.space = (r.glyph == tal_pkg::GLYPH_SPACE);
    // quotes leave the after-space flag alone
    if (code != tal_pkg::CODE_SQUOTE && code != tal_pkg::CODE_DQUOTE) after_sp = r.space;
    if (r.space) begin
      pen_acc = clip_add(int'(pen_acc), int'(space_px));
    end else begin
      pen_acc = clip_add(int'(pen_acc), pair_adv(int'(prev_glyph), int'(r.glyph)));
      prev_glyph = r.glyph;
    end
    r.pen   = pen_acc;
    r.done  = last;
    r.total = last ? clip_add(int'(pen_acc), pair_adv(int'(prev_glyph), 0)) : '0;
    pending_layout.push_back(r);
    if (last) begin
      pen_acc    = '0;
      prev_glyph = tal_pkg::GLYPH_SPACE;
      after_sp   = 1'b1;
      n_strings++;
    end
  endfunction

  // one input word; the predictor runs on the accepting edge
  task automatic put_word(input logic mode, input logic [31:0] data, input logic last);
    while ($urandom_range(99) < gap_pct) begin
      @(negedge clk);
      s_tvalid <= 1'b0;
    end
    @(negedge clk);
    s_tvalid <= 1'b1;
    s_tdata  <= data;
    s_tuser  <= mode;
    s_tlast  <= last;
    do @(posedge clk); while (!s_tready);
    if (mode == tal_pkg::MODE_LAYOUT) begin
      place_char(data[29:22], last);
      n_chars++;
    end else begin
      store_pair(int'(data[6:0]), int'(data[13:7]), int'(data[21:14]));
      n_writes++;
    end
  endtask

  task automatic write_pair(input int first, input int second, input int adv);
    put_word(tal_pkg::MODE_WRITE,
             {2'b00, 8'($urandom), 8'(adv), 7'(second), 7'(first)},
             1'($urandom));
  endtask

  task automatic send_char(input logic [7:0] code, input logic last);
    put_word(tal_pkg::MODE_LAYOUT, {2'b00, code, 22'($urandom)}, last);
  endtask

  task automatic send_text(input string txt);
    for (int i = 0; i < txt.len(); i++) send_char(txt[i], i == txt.len() - 1);
  endtask

  task automatic wait_drained();
    @(negedge clk);
    s_tvalid <= 1'b0;
    while (pending_layout.size() != 0) @(posedge clk);
  endtask

  task automatic set_space_width(input logic [7:0] w);
    wait_drained();
    // table writes give no result; each is written on its accepting edge
    repeat (SETTLE_TICKS) @(posedge clk);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_data  <= w;
    do @(posedge clk); while (!cfg_ready);
    space_px = w;
    n_cfg++;
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  task automatic set_idling(input int gap, input int stall);
    gap_pct   = gap;
    stall_pct = stall;
  endtask

  // codes whose glyph pairs are all loaded, plus every kind of space
  function automatic logic [7:0] pick_code();
    case ($urandom_range(19))
      10, 11, 12: return tal_pkg::FIRST_PRINTABLE;
      13:         return tal_pkg::CODE_SQUOTE;
      14:         return tal_pkg::CODE_DQUOTE;
      15:         return 8'($urandom_range(0, 31));
      16, 17:     return 8'($urandom_range(128, 255));
      18:         return 8'd127;
      19:         return 8'd126;
      default:    return ($urandom_range(1) != 0) ? 8'd65 : 8'd97;
    endcase
  endfunction

  task automatic random_write();
    if ($urandom_range(4) == 0) write_pair($urandom_range(0, 127), $urandom_range(0, 127),
                                           $urandom_range(0, 255));
    else write_pair($urandom_range(1, 97), $urandom_range(0, 97), $urandom_range(0, 255));
  endtask

  // whole strings, with table writes dropped in now and then
  task automatic random_strings(input int n_words);
    int sent;
    int len;
    sent = 0;
    while (sent < n_words) begin
      len = $urandom_range(1, 16);
      for (int i = 0; i < len; i++) begin
        if ($urandom_range(9) == 0) random_write();
        send_char(pick_code(), i == len - 1);
        sent++;
      end
    end
  endtask

  // ---- tests ----

  // before the table is loaded only strings without drawn glyphs are safe
  task automatic test_reset_state();
    send_char(tal_pkg::FIRST_PRINTABLE, 1'b0);
    send_char(8'd0, 1'b0);
    send_char(8'd200, 1'b0);
    send_char(8'd31, 1'b1);
    wait_drained();
  endtask

  task automatic test_space_register();
    set_space_width(8'd0);
    send_char(tal_pkg::FIRST_PRINTABLE, 1'b0);
    send_char(8'd255, 1'b1);
    set_space_width(8'd255);
    send_char(tal_pkg::FIRST_PRINTABLE, 1'b0);
    send_char(tal_pkg::FIRST_PRINTABLE, 1'b1);
    wait_drained();
  endtask

  task automatic test_table_load();
    int adv;
    int first;
    for (int f = 0; f < N_ALPHA; f++) begin
      first = alpha_glyph(f);
      for (int s = -1; s < N_ALPHA; s++) begin
        case ($urandom_range(9))
          0:       adv = 0;
          1:       adv = 255;
          default: adv = $urandom_range(0, 255);
        endcase
        write_pair(first, (s < 0) ? 0 : alpha_glyph(s), adv);
      end
    end
    // writes that must be dropped: glyph 0 row and out-of-range indices
    write_pair(0, 5, 255);
    write_pair(127, 0, 255);
    write_pair(5, 127, 255);
    write_pair(98, 98, 255);
    write_pair(97, 98, 255);
    write_pair(98, 0, 255);
  endtask

  task automatic test_quotes_and_codes();
    set_space_width(8'd3);
    send_text("'");
    send_text("\"a");
    send_text("a 'A");
    send_text("a'a");
    send_text("''");
    send_text("A  ");
    send_char(8'd0, 1'b0);
    send_char(8'd31, 1'b0);
    send_char(8'd126, 1'b0);
    send_char(8'd127, 1'b0);
    send_char(8'd128, 1'b0);
    send_char(8'd255, 1'b1);
    wait_drained();
  endtask

  task automatic test_saturation();
    set_space_width(8'd255);
    write_pair(33, 33, 255);
    write_pair(33, 0, 255);
    repeat (258) send_char(tal_pkg::FIRST_PRINTABLE, 1'b0);
    send_char(8'd65, 1'b0);
    send_char(8'd65, 1'b0);
    send_char(8'd65, 1'b1);
    wait_drained();
  endtask

  task automatic test_backpressure();
    set_idling(0, 0);
    hold_req = 300;
    random_strings(40);
    wait_drained();
  endtask

  task automatic test_random_phases();
    set_idling(0, 0);
    set_space_width(8'd0);
    random_strings(PHASE_WORDS);
    set_space_width(8'd255);
    set_idling(58, 0);
    random_strings(PHASE_WORDS);
    set_space_width(8'($urandom));
    set_idling(0, 58);
    random_strings(PHASE_WORDS);
    set_space_width(8'($urandom));
    set_idling(12, 12);
    random_strings(PHASE_WORDS);
    wait_drained();
  endtask

  // ---- result side ----

  always @(negedge clk) begin
    if (hold_req != 0) begin
      hold_left = hold_req;
      hold_req  = 0;
    end
    if (hold_left > 0) begin
      hold_left--;
      m_tready <= 1'b0;
    end else begin
      m_tready <= ($urandom_range(99) >= stall_pct);
    end
  end

  always @(posedge clk) begin
    layout_res_t want;
    layout_res_t got;
    if (!rst && m_tvalid && m_tready) begin
      got.glyph = m_tdata[6:0];
      got.pen   = m_tdata[22:7];
      got.total = m_tdata[38:23];
      got.space = m_tuser;
      got.done  = m_tlast;
      if (pending_layout.size() == 0) begin
        mism++;
        if (mism <= 10) $display("result word with nothing pending: glyph %0d pen %0d",
                                 got.glyph, got.pen);
      end else begin
        want = pending_layout.pop_front();
        n_checked++;
        if (got.glyph !== want.glyph || got.pen !== want.pen || got.space !== want.space ||
            got.done !== want.done || got.total !== want.total) begin
          mism++;
          if (mism <= 10) begin
            $display("mismatch on word %0d: exp glyph %0d pen %0d sp %0b done %0b total %0d",
                     n_checked, want.glyph, want.pen, want.space, want.done, want.total);
            $display("                         got glyph %0d pen %0d sp %0b done %0b total %0d",
                     got.glyph, got.pen, got.space, got.done, got.total);
          end
        end
      end
    end
  end

  // ---- sequence ----

  initial begin
    rst        = 1'b1;
    cfg_valid  = 1'b0;
    cfg_data   = '0;
    s_tvalid   = 1'b0;
    s_tdata    = '0;
    s_tuser    = 1'b0;
    s_tlast    = 1'b0;
    m_tready   = 1'b0;
    gap_pct    = 0;
    stall_pct  = 0;
    hold_req   = 0;
    hold_left  = 0;
    mism       = 0;
    n_checked  = 0;
    n_chars    = 0;
    n_writes   = 0;
    n_strings  = 0;
    n_cfg      = 0;
    pen_acc    = '0;
    prev_glyph = tal_pkg::GLYPH_SPACE;
    after_sp   = 1'b1;
    space_px   = tal_pkg::SPACE_RESET;
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    test_reset_state();
    test_space_register();
    test_table_load();
    test_quotes_and_codes();
    test_saturation();
    test_backpressure();
    test_random_phases();

    wait_drained();
    repeat (20) @(posedge clk);
    if (pending_layout.size() != 0) begin
      mism += pending_layout.size();
      $display("%0d result words never arrived", pending_layout.size());
    end
    $display("Laid out %0d characters in %0d strings, %0d table words, %0d width settings",
             n_chars, n_strings, n_writes, n_cfg);
    $display("Checked %0d result words, %0d mismatches", n_checked, mism);
    if (mism == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule

// ----- files.f -----
rtl/core/tal_pkg.sv
rtl/core/tal_adv_mem.sv
rtl/core/text_advance_layout_unit.sv
rtl/core/tal_checker.sv
verif/text_advance_layout_unit_test.sv
